// ----- sv/wsd_pkg.sv -----
package wsd_pkg;

	localparam logic [2:0] PH_HEAD0   = 3'd0;
	localparam logic [2:0] PH_HEAD1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	localparam logic [2:0] LEN16_MORE = 3'd1;
	localparam logic [2:0] LEN64_MORE = 3'd7;
	localparam logic [2:0] KEY_LAST   = 3'd3;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [31:0] mask_key;
		logic [63:0] payload_len;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
	} result_t;

endpackage

// ----- sv/wsd_byte_if.sv -----
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- sv/wsd_frame_if.sv -----
interface wsd_frame_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [31:0] mask_key;
	logic [63:0] payload_len;
	logic [7:0]  payload_byte;
	logic        last_of_frame;

	modport source (
		output valid, output kind, output fin, output opcode, output masked,
		output mask_key, output payload_len, output payload_byte,
		output last_of_frame, input ready
	);
	modport sink (
		input valid, input kind, input fin, input opcode, input masked,
		input mask_key, input payload_len, input payload_byte,
		input last_of_frame, output ready
	);
endinterface

// ----- sv/wsd_parser.sv -----
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	output logic             has_res,
	output wsd_pkg::result_t res
);

	logic [2:0]  phase_q, phase_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [7:0]  held_q, held_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        masked_q, masked_n;
	logic [63:0] len_q, len_n;
	logic [31:0] key_q, key_n;
	logic [63:0] passed_q, passed_n;
	logic [6:0]  len_code;
	logic [63:0] passed_inc;
	logic        kind;
	logic        last;

	assign len_code   = data_byte[6:0];
	assign passed_inc = passed_q + 64'd1;

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		held_n   = held_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		len_n    = len_q;
		key_n    = key_q;
		passed_n = passed_q;
		has_res  = 1'b0;
		kind     = wsd_pkg::KIND_HEADER;
		last     = 1'b0;
		case (phase_q)
			wsd_pkg::PH_HEAD1: begin
				fin_n    = held_q[7];
				opcode_n = held_q[3:0];
				masked_n = data_byte[7];
				cnt_n    = 3'd0;
				if (len_code == wsd_pkg::LEN16_CODE) begin
					len_n   = 64'd0;
					cnt_n   = wsd_pkg::LEN16_MORE;
					phase_n = wsd_pkg::PH_EXTLEN;
				end else if (len_code == wsd_pkg::LEN64_CODE) begin
					len_n   = 64'd0;
					cnt_n   = wsd_pkg::LEN64_MORE;
					phase_n = wsd_pkg::PH_EXTLEN;
				end else begin
					len_n = {57'd0, len_code};
					key_n = 32'd0;
					if (data_byte[7]) begin
						phase_n = wsd_pkg::PH_KEY;
					end else begin
						has_res  = 1'b1;
						last     = (len_code == 7'd0);
						passed_n = 64'd0;
						phase_n  = last ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				len_n = {len_q[55:0], data_byte};
				if (cnt_q != 3'd0) begin
					cnt_n = cnt_q - 3'd1;
				end else begin
					key_n = 32'd0;
					if (masked_q) begin
						phase_n = wsd_pkg::PH_KEY;
					end else begin
						has_res  = 1'b1;
						last     = (len_n == 64'd0);
						passed_n = 64'd0;
						phase_n  = last ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n = {key_q[23:0], data_byte};
				if (cnt_q == wsd_pkg::KEY_LAST) begin
					cnt_n    = 3'd0;
					has_res  = 1'b1;
					last     = (len_q == 64'd0);
					passed_n = 64'd0;
					phase_n  = last ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAYLOAD;
				end else begin
					cnt_n = cnt_q + 3'd1;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				has_res = 1'b1;
				kind    = wsd_pkg::KIND_PAYLOAD;
				last    = (passed_inc == len_q);
				if (last) begin
					passed_n = 64'd0;
					phase_n  = wsd_pkg::PH_HEAD0;
				end else begin
					passed_n = passed_inc;
				end
			end
			default: begin
				held_n  = data_byte;
				phase_n = wsd_pkg::PH_HEAD1;
			end
		endcase
	end

	always_comb begin
		res.kind          = kind;
		res.fin           = fin_n;
		res.opcode        = opcode_n;
		res.masked        = masked_n;
		res.mask_key      = masked_n ? key_n : 32'd0;
		res.payload_len   = len_n;
		res.payload_byte  = (kind == wsd_pkg::KIND_PAYLOAD) ? data_byte : 8'd0;
		res.last_of_frame = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_HEAD0;
			cnt_q    <= 3'd0;
			held_q   <= 8'd0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			len_q    <= 64'd0;
			key_q    <= 32'd0;
			passed_q <= 64'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			held_q   <= held_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			len_q    <= len_n;
			key_q    <= key_n;
			passed_q <= passed_n;
		end
	end

`ifndef SYNTHESIS
	a_payload_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == wsd_pkg::PH_PAYLOAD |-> has_res)
		else $error("payload byte produced no result");

	a_header_phase: assert property (@(posedge clk) disable iff (!arst_n)
		has_res && res.kind == wsd_pkg::KIND_HEADER |->
			phase_q == wsd_pkg::PH_HEAD1 || phase_q == wsd_pkg::PH_EXTLEN ||
			phase_q == wsd_pkg::PH_KEY)
		else $error("header result outside header phases");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_res && res.last_of_frame |=> phase_q == wsd_pkg::PH_HEAD0)
		else $error("frame end did not return to head phase");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsd_pkg::PH_PAYLOAD |-> passed_q < len_q)
		else $error("payload count reached frame length");
`endif

endmodule

// ----- sv/wsd_out_reg.sv -----
module wsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  wsd_pkg::result_t res,
	output logic             can_take,
	wsd_frame_if.source      frame
);

	logic             valid_q;
	wsd_pkg::result_t res_q;

	assign can_take = !valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign frame.valid         = valid_q;
	assign frame.kind          = res_q.kind;
	assign frame.fin           = res_q.fin;
	assign frame.opcode        = res_q.opcode;
	assign frame.masked        = res_q.masked;
	assign frame.mask_key      = res_q.mask_key;
	assign frame.payload_len   = res_q.payload_len;
	assign frame.payload_byte  = res_q.payload_byte;
	assign frame.last_of_frame = res_q.last_of_frame;

endmodule

// ----- sv/websocket_frame_deframer.sv -----
// WebSocket frame deframer. Bytes of the incoming stream arrive on the stream
// channel, one per transaction. The frame channel carries one header
// transaction per frame (kind 0) once the two head bytes, any extended length
// and any mask key have arrived, then one transaction per payload byte
// (kind 1), passed through without unmasking. The transaction that ends a
// frame has last_of_frame set; for an empty payload that is the header
// itself. After the end of a frame the next byte is taken as a new head.
// A byte is taken into an input register, decoded combinationally by the
// parser and its result, if any, is loaded into the output register, which
// drives the frame channel. The block takes one byte per cycle while the
// frame channel does not stall; the bound is the parser's 64-bit payload
// count and compare, done once per byte.
// Reset returns the parser to the head phase and empties both registers.
// When the receiver stalls, the output register holds its transaction and the
// input register still takes one more byte; stream ready then falls until the
// frame channel drains. Header bytes that produce no result keep moving.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	wsd_byte_if.sink    stream,
	wsd_frame_if.source frame
);

	logic             byte_valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             has_res;
	logic             can_take;
	wsd_pkg::result_t res;

	assign advance      = byte_valid_s1 && (!has_res || can_take);
	assign stream.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
		end
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.has_res   (has_res),
		.res       (res)
	);

	wsd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_res),
		.res      (res),
		.can_take (can_take),
		.frame    (frame)
	);

`ifndef SYNTHESIS
	a_blocked_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid_s1 && !advance |=> byte_valid_s1 && $stable(byte_s1))
		else $error("blocked byte lost from input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && !frame.ready |-> !(advance && has_res))
		else $error("result loaded over a stalled transaction");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid_s1 |-> stream.ready)
		else $error("stream stalled with empty input register");
`endif

endmodule

// ----- tb/websocket_frame_deframer_test.sv -----
module websocket_frame_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int END_SETTLE = 20;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int LONG_HOLD_AFTER = 300;

	localparam logic [1:0] LEN_SHORT = 2'd0;
	localparam logic [1:0] LEN_16 = 2'd1;
	localparam logic [1:0] LEN_64 = 2'd2;

	typedef struct {
		logic [7:0] value;
		bit         wait_drain;
	} planned_byte_t;

	logic clk;
	logic arst_n;

	wsd_byte_if  stream();
	wsd_frame_if frame();

	websocket_frame_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.frame  (frame)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	planned_byte_t     stream_plan[$];
	wsd_pkg::result_t  frames_due[$];
	bit                drain_next;

	int  mismatch_count;
	int  results_seen;
	int  cycle_count;
	int  send_gap;
	int  send_calm;
	int  recv_stall;
	int  recv_calm;
	int  long_hold_left;
	bit  long_hold_done;
	bit  byte_taken;

	// Parser state mirrored by the scoreboard.
	logic [2:0]  parse_phase;
	logic [3:0]  field_left;
	logic [7:0]  held_head;
	logic        cur_fin;
	logic [3:0]  cur_opcode;
	logic        cur_masked;
	logic [63:0] cur_len;
	logic [31:0] cur_key;
	logic [63:0] payload_count;

	function automatic int pick_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_frame_result(logic kind, logic [7:0] data, logic last);
		wsd_pkg::result_t r;
		r.kind = kind;
		r.fin = cur_fin;
		r.opcode = cur_opcode;
		r.masked = cur_masked;
		r.mask_key = cur_masked ? cur_key : 32'd0;
		r.payload_len = cur_len;
		r.payload_byte = data;
		r.last_of_frame = last;
		frames_due.push_back(r);
	endfunction

	function automatic void close_header();
		logic empty;
		empty = (cur_len == 64'd0);
		push_frame_result(wsd_pkg::KIND_HEADER, 8'd0, empty);
		payload_count = 64'd0;
		field_left = 4'd0;
		parse_phase = empty ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAYLOAD;
	endfunction

	function automatic void close_length();
		field_left = 4'd0;
		cur_key = 32'd0;
		if (cur_masked)
			parse_phase = wsd_pkg::PH_KEY;
		else
			close_header();
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		logic last;
		case (parse_phase)
			wsd_pkg::PH_HEAD1: begin
				cur_fin = held_head[7];
				cur_opcode = held_head[3:0];
				cur_masked = b[7];
				cur_len = 64'd0;
				field_left = 4'd0;
				if (b[6:0] == wsd_pkg::LEN16_CODE) begin
					field_left = 4'd2;
					parse_phase = wsd_pkg::PH_EXTLEN;
				end else if (b[6:0] == wsd_pkg::LEN64_CODE) begin
					field_left = 4'd8;
					parse_phase = wsd_pkg::PH_EXTLEN;
				end else begin
					cur_len = {57'd0, b[6:0]};
					close_length();
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				cur_len = {cur_len[55:0], b};
				if (field_left != 4'd0)
					field_left--;
				if (field_left == 4'd0)
					close_length();
			end
			wsd_pkg::PH_KEY: begin
				cur_key = {cur_key[23:0], b};
				field_left = (field_left + 4'd1) & 4'd7;
				if (field_left >= 4'd4)
					close_header();
			end
			wsd_pkg::PH_PAYLOAD: begin
				payload_count = payload_count + 64'd1;
				last = (payload_count == cur_len);
				push_frame_result(wsd_pkg::KIND_PAYLOAD, b, last);
				if (last) begin
					parse_phase = wsd_pkg::PH_HEAD0;
					payload_count = 64'd0;
				end
			end
			default: begin
				held_head = b;
				parse_phase = wsd_pkg::PH_HEAD1;
			end
		endcase
	endfunction

	task automatic note_mismatch(string msg);
		$display("[%0t] frame check: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			note_mismatch($sformatf("field %s got %0h want %0h", name, got, want));
	endtask

	task automatic add_byte(logic [7:0] value);
		planned_byte_t p;
		p.value = value;
		p.wait_drain = drain_next;
		drain_next = 1'b0;
		stream_plan.push_back(p);
	endtask

	task automatic add_frame(logic [7:0] head, logic masked, logic [1:0] len_form,
			logic [63:0] len, int body_bytes);
		add_byte(head);
		case (len_form)
			LEN_16: begin
				add_byte({masked, wsd_pkg::LEN16_CODE});
				for (int i = 1; i >= 0; i--)
					add_byte(len[i*8 +: 8]);
			end
			LEN_64: begin
				add_byte({masked, wsd_pkg::LEN64_CODE});
				for (int i = 7; i >= 0; i--)
					add_byte(len[i*8 +: 8]);
			end
			default: add_byte({masked, len[6:0]});
		endcase
		if (masked)
			for (int i = 0; i < 4; i++)
				add_byte(8'($urandom()));
		for (int i = 0; i < body_bytes; i++)
			add_byte(8'($urandom()));
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		byte_taken <= (arst_n === 1'b1) && stream.valid && stream.ready;
		if (arst_n === 1'b1 && stream.valid && stream.ready)
			parse_byte(stream.data_byte);
	end

	always @(posedge clk) begin
		wsd_pkg::result_t want;
		if (arst_n === 1'b1 && frame.valid && frame.ready) begin
			results_seen++;
			if (frames_due.size() == 0) begin
				note_mismatch($sformatf("unexpected transaction kind %0d byte %0h",
					frame.kind, frame.payload_byte));
			end else begin
				want = frames_due.pop_front();
				check_field("kind", 64'(frame.kind), 64'(want.kind));
				check_field("fin", 64'(frame.fin), 64'(want.fin));
				check_field("opcode", 64'(frame.opcode), 64'(want.opcode));
				check_field("masked", 64'(frame.masked), 64'(want.masked));
				check_field("mask_key", 64'(frame.mask_key), 64'(want.mask_key));
				check_field("payload_len", frame.payload_len, want.payload_len);
				check_field("payload_byte", 64'(frame.payload_byte),
					64'(want.payload_byte));
				check_field("last_of_frame", 64'(frame.last_of_frame),
					64'(want.last_of_frame));
			end
		end
	end

	always @(negedge clk) begin
		logic       next_valid;
		logic [7:0] next_byte;
		next_valid = stream.valid;
		next_byte = stream.data_byte;
		if (arst_n !== 1'b1) begin
			next_valid = 1'b0;
		end else if (!stream.valid || byte_taken) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (stream_plan.size() > 0 &&
					!(stream_plan[0].wait_drain && frames_due.size() != 0)) begin
				next_valid = 1'b1;
				next_byte = stream_plan[0].value;
				stream_plan.pop_front();
				send_gap = pick_gap(send_calm);
			end
		end
		stream.valid <= next_valid;
		stream.data_byte <= next_byte;
	end

	// The receiver holds off once for a long stretch so that the block backs up.
	always @(negedge clk) begin
		logic next_ready;
		if (arst_n !== 1'b1) begin
			next_ready = 1'b0;
		end else begin
			if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				long_hold_left = LONG_HOLD_CYCLES;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				next_ready = 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				next_ready = 1'b0;
			end else begin
				recv_stall = pick_gap(recv_calm);
				next_ready = (recv_stall == 0);
				if (recv_stall > 0)
					recv_stall--;
			end
		end
		frame.ready <= next_ready;
	end

	initial begin
		int          r;
		int          len;
		logic        masked;
		logic [63:0] big_len;
		bit          mid_drain_done;

		arst_n = 1'b0;
		stream.valid = 1'b0;
		stream.data_byte = 8'd0;
		frame.ready = 1'b0;
		parse_phase = wsd_pkg::PH_HEAD0;
		field_left = 4'd0;
		held_head = 8'd0;
		cur_fin = 1'b0;
		cur_opcode = 4'd0;
		cur_masked = 1'b0;
		cur_len = 64'd0;
		cur_key = 32'd0;
		payload_count = 64'd0;
		mid_drain_done = 1'b0;

		// Empty frame, then reserved bits with every opcode bit set and a mask key.
		add_frame(8'h81, 1'b0, LEN_SHORT, 64'd0, 0);
		add_frame(8'h7F, 1'b1, LEN_SHORT, 64'd0, 0);
		// Non-minimal 16-bit and 64-bit extended lengths.
		drain_next = 1'b1;
		add_frame(8'h0A, 1'b0, LEN_16, 64'd2, 2);
		add_frame(8'hF0, 1'b1, LEN_64, 64'd1, 1);

		drain_next = 1'b1;
		while (stream_plan.size() < 1040) begin
			if (!mid_drain_done && stream_plan.size() > 520) begin
				mid_drain_done = 1'b1;
				drain_next = 1'b1;
			end
			r = $urandom_range(0, 99);
			masked = 1'($urandom());
			if (r < 70) begin
				len = $urandom_range(0, 12);
				add_frame(8'($urandom()), masked, LEN_SHORT, 64'(len), len);
			end else if (r < 76) begin
				len = $urandom_range(100, 125);
				add_frame(8'($urandom()), masked, LEN_SHORT, 64'(len), len);
			end else if (r < 86) begin
				len = $urandom_range(0, 20);
				add_frame(8'($urandom()), masked, LEN_16, 64'(len), len);
			end else if (r < 88 && stream_plan.size() < 700) begin
				len = $urandom_range(126, 300);
				add_frame(8'($urandom()), masked, LEN_16, 64'(len), len);
			end else begin
				len = $urandom_range(0, 16);
				add_frame(8'($urandom()), masked, LEN_64, 64'(len), len);
			end
		end
		// A 64-bit length with the top bit set never completes; it closes the stream.
		big_len = {1'b1, 31'($urandom()), 32'($urandom())};
		add_frame(8'($urandom()), 1'($urandom()), LEN_64, big_len, 6);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stream_plan.size() != 0 || stream.valid)
			@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/wsd_pkg.sv
sv/wsd_byte_if.sv
sv/wsd_frame_if.sv
sv/wsd_parser.sv
sv/wsd_out_reg.sv
sv/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
